// File: src/voxel_neighbour_finder_top_defines.svh
// Assertion macros used by the file that checks the voxel neighbour finder.
`ifndef VOXEL_NEIGHBOUR_FINDER_TOP_DEFINES_SVH
`define VOXEL_NEIGHBOUR_FINDER_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define VNF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voxel neighbour finder assertion failed");
// Next-cycle implication.
`define VNF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voxel neighbour finder assertion failed");
`else
`define VNF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VNF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/vnf_pkg.sv
`timescale 1ns / 1ps

package vnf_pkg;

    localparam int IDX_W    = 20;
    localparam int VAL_W    = 21;
    localparam int DIM_W    = 9;
    localparam int CONN_W   = 5;
    localparam int COORD_W  = 8;
    localparam int ID_W     = 25;
    localparam int DXY_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_OFFSETS = 26;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONN  = 2'd3;

    typedef logic signed [1:0] t_off;

    localparam t_off OP = 2'sb01;
    localparam t_off OM = 2'sb11;
    localparam t_off OZ = 2'sb00;

    // Faces first, then edges, then corners.
    localparam t_off OFF_X [NUM_OFFSETS] = '{
        OP, OM, OZ, OZ, OZ, OZ, OP, OM, OP, OM, OP, OM, OP,
        OM, OZ, OZ, OZ, OZ, OP, OM, OP, OM, OP, OM, OP, OM};
    localparam t_off OFF_Y [NUM_OFFSETS] = '{
        OZ, OZ, OP, OM, OZ, OZ, OP, OP, OM, OM, OZ, OZ, OZ,
        OZ, OP, OM, OP, OM, OP, OP, OM, OM, OP, OP, OM, OM};
    localparam t_off OFF_Z [NUM_OFFSETS] = '{
        OZ, OZ, OZ, OZ, OP, OM, OZ, OZ, OZ, OZ, OP, OP, OM,
        OM, OP, OP, OM, OM, OP, OP, OP, OP, OM, OM, OM, OM};

    typedef struct packed {
        logic mem_write;
        logic load_query;
        logic div_start;
        logic div_sel;
        logic cap_x;
        logic cap_yz;
        logic clr_loop;
        logic calc;
        logic addr;
        logic check_step;
        logic push_held;
        logic finish_push;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic hit;
        logic held_valid;
        logic out_free;
        logic last_offset;
        logic conn_zero;
    } t_dp_sts;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] res;
        res = d;
        if (d == '0) begin
            res = 9'd1;
        end else if (d > 9'd256) begin
            res = 9'd256;
        end
        return res;
    endfunction

endpackage

// File: src/vnf_divider.sv
`timescale 1ns / 1ps

module vnf_divider import vnf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [IDX_W-1:0] i_dividend,
    input  logic [DIM_W-1:0] i_divisor,
    output logic             o_done,
    output logic [IDX_W-1:0] o_quot,
    output logic [DIM_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(IDX_W + 1);

    logic [IDX_W-1:0] r_quot;
    logic [DIM_W-1:0] r_rem;
    logic [DIM_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIM_W:0]   trial;
    logic             ge;
    logic [DIM_W:0]   diff;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        trial = {r_rem, r_quot[IDX_W-1]};
        ge    = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(IDX_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[IDX_W-2:0], ge};
            r_rem  <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// File: src/vnf_datapath.sv
`timescale 1ns / 1ps

module vnf_datapath import vnf_pkg::*; #(
    parameter int MAX_VOXELS = 1048576,
    parameter int MAX_CONN   = 26
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic [IDX_W-1:0]     i_voxel_index,
    input  logic [VAL_W-1:0]     i_mask_value,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [VAL_W-1:0]     o_neighbour_order,
    output logic                 o_found,
    output logic                 o_last
);

    localparam int AW = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;
    localparam logic [ID_W-1:0]   MAX_ID   = ID_W'(MAX_VOXELS);
    localparam logic [CONN_W-1:0] CONN_LIM = CONN_W'(MAX_CONN);

    logic [DIM_W-1:0]  r_cfg_dim_x;
    logic [DIM_W-1:0]  r_cfg_dim_y;
    logic [DIM_W-1:0]  r_cfg_dim_z;
    logic [CONN_W-1:0] r_cfg_conn;

    logic [DIM_W-1:0]  r_dx;
    logic [DIM_W-1:0]  r_dy;
    logic [DIM_W-1:0]  r_dz;
    logic [DXY_W-1:0]  r_dxy;
    logic [CONN_W-1:0] r_conn;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [IDX_W-1:0]  r_z;
    logic [CONN_W-1:0] r_k;

    logic              r_inb;
    logic [ID_W-1:0]   r_zprod;
    logic [DXY_W-1:0]  r_yprod;
    logic [COORD_W-1:0] r_nx;
    logic              r_rd_ok;
    logic [VAL_W-1:0]  r_rd_data;
    logic [VAL_W-1:0]  r_held;
    logic              r_held_valid;

    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_order;
    logic              r_out_found;
    logic              r_out_last;

    logic [VAL_W-1:0]  r_mask_mem [MAX_VOXELS];

    logic [DIM_W-1:0]  dx_eff;
    logic [DIM_W-1:0]  dy_eff;
    logic [CONN_W-1:0] conn_eff;
    logic [IDX_W-1:0]  div_dividend;
    logic [DIM_W-1:0]  div_divisor;
    logic              div_done;
    logic [IDX_W-1:0]  div_quot;
    logic [DIM_W-1:0]  div_rem;

    t_off              ox;
    t_off              oy;
    t_off              oz;
    logic signed [DIM_W:0]   nx_s;
    logic signed [DIM_W:0]   ny_s;
    logic signed [IDX_W+1:0] nz_s;
    logic              inb;
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   wr_ext;
    logic              hit;

    always_comb begin
        dx_eff   = clamp_dim(r_cfg_dim_x);
        dy_eff   = clamp_dim(r_cfg_dim_y);
        conn_eff = (r_cfg_conn > CONN_LIM) ? CONN_LIM : r_cfg_conn;
        div_dividend = i_cmd.div_sel ? div_quot : i_voxel_index;
        div_divisor  = i_cmd.div_sel ? r_dy : dx_eff;
    end

    vnf_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dim_x <= 9'd1;
            r_cfg_dim_y <= 9'd1;
            r_cfg_dim_z <= 9'd1;
            r_cfg_conn  <= 5'd6;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DIM_X: r_cfg_dim_x <= i_cfg_data;
                REG_DIM_Y: r_cfg_dim_y <= i_cfg_data;
                REG_DIM_Z: r_cfg_dim_z <= i_cfg_data;
                REG_CONN:  r_cfg_conn  <= i_cfg_data[CONN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Neighbour coordinates for the current table offset.
    always_comb begin
        ox   = OFF_X[r_k];
        oy   = OFF_Y[r_k];
        oz   = OFF_Z[r_k];
        nx_s = $signed({2'b00, r_x}) + $signed({{(DIM_W-1){ox[1]}}, ox});
        ny_s = $signed({2'b00, r_y}) + $signed({{(DIM_W-1){oy[1]}}, oy});
        nz_s = $signed({2'b00, r_z}) + $signed({{IDX_W{oz[1]}}, oz});
        inb  = !nx_s[DIM_W] && (nx_s[DIM_W-1:0] < r_dx)
            && !ny_s[DIM_W] && (ny_s[DIM_W-1:0] < r_dy)
            && !nz_s[IDX_W+1] && (nz_s[IDX_W:0] < {12'd0, r_dz});
        id     = r_zprod + ID_W'(r_yprod) + ID_W'(r_nx);
        wr_ext = ID_W'(i_voxel_index);
        hit    = r_rd_ok && (r_rd_data != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_dx   <= dx_eff;
            r_dy   <= dy_eff;
            r_dz   <= clamp_dim(r_cfg_dim_z);
            r_dxy  <= DXY_W'(dx_eff) * DXY_W'(dy_eff);
            r_conn <= conn_eff;
        end
        if (i_cmd.cap_x) begin
            r_x <= div_rem[COORD_W-1:0];
        end
        if (i_cmd.cap_yz) begin
            r_y <= div_rem[COORD_W-1:0];
            r_z <= div_quot;
        end
        if (i_cmd.calc) begin
            r_inb   <= inb;
            r_nx    <= nx_s[COORD_W-1:0];
            r_zprod <= ID_W'(nz_s[COORD_W-1:0]) * ID_W'(r_dxy);
            r_yprod <= DXY_W'(ny_s[COORD_W-1:0]) * DXY_W'(r_dx);
        end
        if (i_cmd.check_step && hit) begin
            r_held <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write && (wr_ext < MAX_ID)) begin
            r_mask_mem[wr_ext[AW-1:0]] <= i_mask_value;
        end
        if (i_cmd.addr) begin
            r_rd_data <= r_mask_mem[id[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k          <= '0;
            r_held_valid <= 1'b0;
            r_rd_ok      <= 1'b0;
        end else begin
            if (i_cmd.clr_loop) begin
                r_k          <= '0;
                r_held_valid <= 1'b0;
            end else if (i_cmd.check_step) begin
                r_k <= r_k + CONN_W'(1);
                if (hit) begin
                    r_held_valid <= 1'b1;
                end
            end
            if (i_cmd.addr) begin
                r_rd_ok <= r_inb && (id < MAX_ID);
            end
        end
    end

    // The held register keeps back one hit so that the final one can carry last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_held || i_cmd.finish_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_held) begin
            r_out_order <= r_held;
            r_out_found <= 1'b1;
            r_out_last  <= 1'b0;
        end else if (i_cmd.finish_push) begin
            r_out_order <= r_held_valid ? r_held : '0;
            r_out_found <= r_held_valid;
            r_out_last  <= 1'b1;
        end
    end

    always_comb begin
        o_sts.div_done    = div_done;
        o_sts.hit         = hit;
        o_sts.held_valid  = r_held_valid;
        o_sts.out_free    = !r_out_valid || i_out_ready;
        o_sts.last_offset = ({1'b0, r_k} + 6'd1) >= {1'b0, r_conn};
        o_sts.conn_zero   = (r_conn == '0);
    end

    assign o_out_valid       = r_out_valid;
    assign o_neighbour_order = r_out_order;
    assign o_found           = r_out_found;
    assign o_last            = r_out_last;

endmodule

// File: src/vnf_ctrl.sv
`timescale 1ns / 1ps

module vnf_ctrl import vnf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_command,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV1   = 3'd1;
    localparam logic [2:0] S_DIV2   = 3'd2;
    localparam logic [2:0] S_CALC   = 3'd3;
    localparam logic [2:0] S_ADDR   = 3'd4;
    localparam logic [2:0] S_CHECK  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_command == CMD_WRITE) begin
                        o_cmd.mem_write = 1'b1;
                    end else begin
                        o_cmd.load_query = 1'b1;
                        o_cmd.div_start  = 1'b1;
                        n_state          = S_DIV1;
                    end
                end
            end
            S_DIV1: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_x     = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = 1'b1;
                    n_state         = S_DIV2;
                end
            end
            S_DIV2: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_yz   = 1'b1;
                    o_cmd.clr_loop = 1'b1;
                    n_state        = i_sts.conn_zero ? S_FINISH : S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                // A second hit displaces the held one, which needs a free result slot.
                if (!(i_sts.hit && i_sts.held_valid && !i_sts.out_free)) begin
                    o_cmd.check_step = 1'b1;
                    o_cmd.push_held  = i_sts.hit && i_sts.held_valid;
                    n_state          = i_sts.last_offset ? S_FINISH : S_CALC;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish_push = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

// File: src/voxel_neighbour_finder_top.sv
`timescale 1ns / 1ps
`include "voxel_neighbour_finder_top_defines.svh"

// Voxel neighbour finder. A write transaction (command 0) stores one mask entry. A query
// transaction (command 1) splits the voxel index into x, y and z with one shared radix-2
// divider used for two divisions, then visits the first connectivity offsets of the face,
// edge and corner table, each in turn through coordinate and product, address and mask memory
// read, and test; the test waits while a second hit finds the result slot full. Each in-mask
// neighbour is returned in table order as one result transaction; the last one is marked, and
// a query without neighbours returns a single result with found low. The mask memory has no
// reset: read only entries that were written. Configuration writes are always accepted and
// must be issued only while the block is idle.
module voxel_neighbour_finder_top import vnf_pkg::*; #(
    parameter int MAX_VOXELS = 1048576,
    parameter int MAX_CONN   = 26
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_command,
    input  logic [IDX_W-1:0]     i_voxel_index,
    input  logic [VAL_W-1:0]     i_mask_value,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [VAL_W-1:0]     o_neighbour_order,
    output logic                 o_found,
    output logic                 o_last
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_push;

    assign o_cfg_ready = 1'b1;
    assign w_push      = w_cmd.push_held || w_cmd.finish_push;

    vnf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_ready   (o_ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    vnf_datapath #(
        .MAX_VOXELS (MAX_VOXELS),
        .MAX_CONN   (MAX_CONN)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_voxel_index     (i_voxel_index),
        .i_mask_value      (i_mask_value),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_out_ready       (i_ready),
        .o_out_valid       (o_valid),
        .o_neighbour_order (o_neighbour_order),
        .o_found           (o_found),
        .o_last            (o_last)
    );

    `VNF_ASSERT_IMPL(a_div_only_in_query, i_clk, i_rst_n, w_sts.div_done, !o_ready)
    `VNF_ASSERT_IMPL(a_push_into_free_slot, i_clk, i_rst_n, w_push, w_sts.out_free)
    `VNF_ASSERT_NEXT(a_finish_marks_last, i_clk, i_rst_n, w_cmd.finish_push, o_valid && o_last)
    `VNF_ASSERT_IMPL(a_empty_is_last, i_clk, i_rst_n, o_valid && !o_found, o_last)

endmodule
